>>> design/hltf_pkg.sv
// Shared types and constants for the header/length/tail frame parser.
`default_nettype none
package hltf_pkg;

  localparam int unsigned CntMaxW = 7;  // holds a payload count up to 127

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_HEADER_FIRST   = 3'd0,
    CFG_HEADER_SECOND  = 3'd1,
    CFG_PAYLOAD_LENGTH = 3'd2,
    CFG_TRAILER_FIRST  = 3'd3,
    CFG_TRAILER_SECOND = 3'd4
  } hltf_cfg_idx_t;

  localparam logic [7:0] RstHeaderFirst   = 8'h55;
  localparam logic [7:0] RstHeaderSecond  = 8'h22;
  localparam logic [5:0] RstPayloadLength = 6'd32;
  localparam logic [7:0] RstTrailerFirst  = 8'h01;
  localparam logic [7:0] RstTrailerSecond = 8'hAA;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_HDR2  = 3'd2,
    PH_DATA  = 3'd3,
    PH_TAIL1 = 3'd4
  } hltf_phase_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [5:0] payload_length;
    logic [7:0] trailer_first;
    logic [7:0] trailer_second;
  } hltf_cfg_t;

  // Parser to buffer: payload write and frame commit share the count field
  typedef struct packed {
    logic               wr_en;
    logic               commit;
    logic [CntMaxW-1:0] count;
    logic [7:0]         data;
  } hltf_req_t;

endpackage
`default_nettype wire

>>> design/hltf_in_if.sv
// Received-byte channel interface.
`default_nettype none
interface hltf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

>>> design/hltf_out_if.sv
// Payload result channel interface.
`default_nettype none
interface hltf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [4:0] payload_index;
  logic       last_byte;

  modport source (output valid, output payload_byte, output payload_index,
                  output last_byte, input ready);
  modport sink (input valid, input payload_byte, input payload_index,
                input last_byte, output ready);
endinterface
`default_nettype wire

>>> design/hltf_parser.sv
// Frame parser state machine and payload count.
`default_nettype none
module hltf_parser import hltf_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire hltf_cfg_t  cfg,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output hltf_req_t       req
);

  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CntMaxW-1:0] MaxLen = CntMaxW'(MAX_PAYLOAD);

  hltf_phase_t        phase_r, phase_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CntMaxW-1:0] len_ext;
  logic [CntMaxW-1:0] frame_len;
  logic               below;

  always_comb begin
    len_ext   = {1'b0, cfg.payload_length};
    frame_len = (len_ext > MaxLen) ? MaxLen : len_ext;
    below     = CntMaxW'(cnt_r) < frame_len;
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_IDLE:  if (rx_byte == cfg.header_first) phase_nxt = PH_HDR1;
        PH_HDR1:  phase_nxt = (rx_byte == cfg.header_second) ? PH_HDR2 : PH_IDLE;
        PH_HDR2:  phase_nxt = (rx_byte == {2'b00, cfg.payload_length}) ? PH_DATA : PH_IDLE;
        PH_DATA: begin
          if (!below) phase_nxt = (rx_byte == cfg.trailer_first) ? PH_TAIL1 : PH_IDLE;
        end
        PH_TAIL1: phase_nxt = PH_IDLE;
        default:  phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Outputs and count
  always_comb begin
    cnt_nxt    = cnt_r;
    req.wr_en  = 1'b0;
    req.commit = 1'b0;
    req.count  = CntMaxW'(cnt_r);
    req.data   = rx_byte;
    if (accept) begin
      unique case (phase_r)
        PH_HDR2: begin
          if (rx_byte == {2'b00, cfg.payload_length}) cnt_nxt = '0;
        end
        PH_DATA: begin
          if (below) begin
            req.wr_en = 1'b1;
            cnt_nxt   = cnt_r + CW'(1);
          end
        end
        PH_TAIL1: req.commit = (rx_byte == cfg.trailer_second);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CntMaxW'(cnt_r) <= MaxLen)
    else $error("payload count beyond buffer depth");

  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.commit |=> phase_r == PH_IDLE)
    else $error("parser not idle after commit");

endmodule
`default_nettype wire

>>> design/hltf_drain.sv
// Payload buffer memory and drain sequencer with registered output.
`default_nettype none
module hltf_drain import hltf_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire hltf_req_t req,
  output logic           busy,
  hltf_out_if.source     out_ch
);

  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]    mem [MAX_PAYLOAD];
  logic [7:0]    rdata_r;
  logic [CW-1:0] rd_cnt_r;
  logic [CW-1:0] n_r;
  logic          draining_r;
  logic          out_valid_r;
  logic [4:0]    idx_r;
  logic          last_r;
  logic          advance;
  logic          issue;
  logic          issue_last;
  logic [CW+4:0] rd_cnt_ext;

  assign advance    = !out_valid_r || out_ch.ready;
  assign issue      = draining_r && advance;
  assign issue_last = (rd_cnt_r + CW'(1)) == n_r;
  assign rd_cnt_ext = (CW + 5)'(rd_cnt_r);
  assign busy       = draining_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.count[AW-1:0]] <= req.data;
  end

  // Read data register advances only when the output stage frees up
  always_ff @(posedge clk) begin
    if (issue) begin
      rdata_r <= mem[rd_cnt_r[AW-1:0]];
      idx_r   <= rd_cnt_ext[4:0];
      last_r  <= issue_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rd_cnt_r    <= '0;
      n_r         <= '0;
    end else begin
      if (advance) out_valid_r <= issue;
      if (req.commit) begin
        n_r        <= req.count[CW-1:0];
        rd_cnt_r   <= '0;
        draining_r <= (req.count != '0);
      end else if (issue) begin
        rd_cnt_r <= rd_cnt_r + CW'(1);
        if (issue_last) draining_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.payload_byte  = rdata_r;
  assign out_ch.payload_index = idx_r;
  assign out_ch.last_byte     = last_r;

  a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r |-> !req.wr_en && !req.commit)
    else $error("buffer written while draining");

  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r |-> rd_cnt_r < n_r)
    else $error("drain read past stored count");

  // A new frame may commit while the previous last beat still waits
  a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && last_r |-> !draining_r || rd_cnt_r == '0)
    else $error("last beat shown while reads of its frame remain");

endmodule
`default_nettype wire

>>> design/header_length_tail_frame_parser_core.sv
// Header/length/tail frame parser: top level with configuration registers.
// Output: the byte matching the second trailer sets draining_r; the first beat is then
//   read into rdata_r, and further beats follow one per cycle while out_ch.ready holds.
// Throughput: one received byte per cycle while parsing; after a commit of a nonempty
//   payload the input stalls while the single buffer read port drains.
// Reset: synchronous, active low; clears parser phase, count, drain and registers
//   to their defaults. The payload buffer is not cleared.
`default_nettype none
module header_length_tail_frame_parser_core import hltf_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  hltf_in_if.sink         in_ch,
  hltf_out_if.source      out_ch
);

  hltf_cfg_t cfg_r;
  hltf_req_t req;
  logic      busy;
  logic      accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first   <= RstHeaderFirst;
      cfg_r.header_second  <= RstHeaderSecond;
      cfg_r.payload_length <= RstPayloadLength;
      cfg_r.trailer_first  <= RstTrailerFirst;
      cfg_r.trailer_second <= RstTrailerSecond;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER_FIRST:   cfg_r.header_first   <= cfg_wdata;
        CFG_HEADER_SECOND:  cfg_r.header_second  <= cfg_wdata;
        CFG_PAYLOAD_LENGTH: cfg_r.payload_length <= cfg_wdata[5:0];
        CFG_TRAILER_FIRST:  cfg_r.trailer_first  <= cfg_wdata;
        CFG_TRAILER_SECOND: cfg_r.trailer_second <= cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && !busy;

  hltf_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .accept  (accept),
    .rx_byte (in_ch.rx_byte),
    .req     (req)
  );

  hltf_drain #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_drain (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .busy   (busy),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the header/length/tail frame parser core.
`timescale 1ns / 1ps
`default_nettype none
module testbench import hltf_pkg::*;;

  localparam int unsigned MaxPayload   = 32;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned IdleLimit    = 3000;
  // Register indexes past the last register; writes there must be ignored
  localparam logic [2:0] CFG_SPARE_LO = 3'd5;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    logic [7:0] payload_byte;
    logic [4:0] payload_index;
    logic       last_byte;
  } payload_beat_t;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_HDR2,
    FRAME_BAD_LEN,
    FRAME_BAD_TAIL1,
    FRAME_BAD_TAIL2,
    FRAME_SHORT,
    FRAME_NOISE
  } frame_kind_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_wdata;

  hltf_in_if  rx_ch ();
  hltf_out_if payload_ch ();

  header_length_tail_frame_parser_core #(
    .MAX_PAYLOAD(MaxPayload)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (rx_ch),
    .out_ch   (payload_ch)
  );

  // Predicted parser state and register copy
  hltf_cfg_t     cfg_shadow;
  hltf_phase_t   frame_phase;
  int unsigned   stored_count;
  logic [7:0]    stored_bytes [MaxPayload];

  logic [7:0]    rx_pending [$];
  payload_beat_t payload_beats_due [$];

  int unsigned   mismatch_count;
  int unsigned   long_holds_wanted;
  int unsigned   long_holds_done;
  bit            src_idle_on;
  bit            sink_idle_on;
  int unsigned   src_gap_left;
  int unsigned   sink_stall_left;
  int unsigned   quiet_cycles;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned frame_cap();
    if (cfg_shadow.payload_length > MaxPayload) return MaxPayload;
    return cfg_shadow.payload_length;
  endfunction

  // Advance the predicted parser by one received byte; queue the beats of a commit
  task automatic parse_rx_byte(input logic [7:0] b);
    payload_beat_t beat;
    case (frame_phase)
      PH_IDLE: begin
        if (b == cfg_shadow.header_first) frame_phase = PH_HDR1;
      end
      PH_HDR1: begin
        if (b == cfg_shadow.header_second) frame_phase = PH_HDR2;
        else frame_phase = PH_IDLE;
      end
      PH_HDR2: begin
        if (b == {2'b00, cfg_shadow.payload_length}) begin
          frame_phase  = PH_DATA;
          stored_count = 0;
        end else begin
          frame_phase = PH_IDLE;
        end
      end
      PH_DATA: begin
        if (stored_count < frame_cap()) begin
          stored_bytes[stored_count] = b;
          stored_count++;
        end else if (b == cfg_shadow.trailer_first) begin
          frame_phase = PH_TAIL1;
        end else begin
          frame_phase = PH_IDLE;
        end
      end
      PH_TAIL1: begin
        if (b == cfg_shadow.trailer_second) begin
          for (int unsigned k = 0; k < stored_count; k++) begin
            beat.payload_byte  = stored_bytes[k];
            beat.payload_index = k[4:0];
            beat.last_byte     = (k + 1 == stored_count);
            payload_beats_due.push_back(beat);
          end
        end
        frame_phase = PH_IDLE;
      end
      default: frame_phase = PH_IDLE;
    endcase
  endtask

  // Sender: offer pending bytes, hold while stalled, idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_ch.valid  <= 1'b0;
      src_gap_left = 0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) parse_rx_byte(rx_ch.rx_byte);
      if (rx_ch.valid && !rx_ch.ready) begin
        // hold the beat
      end else if (src_gap_left > 0) begin
        rx_ch.valid <= 1'b0;
        src_gap_left--;
      end else if (rx_pending.size() > 0) begin
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= rx_pending.pop_front();
        if (src_idle_on && $urandom_range(0, 2) == 0) src_gap_left = pick_gap();
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: check each payload beat against the oldest prediction
  always @(posedge clk) begin
    payload_beat_t due;
    if (!rst_n) begin
      payload_ch.ready <= 1'b0;
      sink_stall_left = 0;
    end else begin
      if (payload_ch.valid && payload_ch.ready) begin
        if (payload_beats_due.size() == 0) begin
          $error("unexpected payload beat: byte %0h index %0d last %0b",
                 payload_ch.payload_byte, payload_ch.payload_index, payload_ch.last_byte);
          mismatch_count++;
        end else begin
          due = payload_beats_due.pop_front();
          if (payload_ch.payload_byte !== due.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h",
                   due.payload_byte, payload_ch.payload_byte);
            mismatch_count++;
          end
          if (payload_ch.payload_index !== due.payload_index) begin
            $error("payload_index: expected %0d, got %0d",
                   due.payload_index, payload_ch.payload_index);
            mismatch_count++;
          end
          if (payload_ch.last_byte !== due.last_byte) begin
            $error("last_byte: expected %0b, got %0b", due.last_byte, payload_ch.last_byte);
            mismatch_count++;
          end
        end
      end
      if (sink_stall_left > 0) begin
        payload_ch.ready <= 1'b0;
        sink_stall_left--;
      end else if (long_holds_done < long_holds_wanted) begin
        payload_ch.ready <= 1'b0;
        sink_stall_left = LongHold - 1;
        long_holds_done++;
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        payload_ch.ready <= 1'b0;
        sink_stall_left = pick_gap() - 1;
      end else begin
        payload_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (rx_ch.valid && rx_ch.ready) || (payload_ch.valid && payload_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HEADER_FIRST:   cfg_shadow.header_first   = value;
      CFG_HEADER_SECOND:  cfg_shadow.header_second  = value;
      CFG_PAYLOAD_LENGTH: cfg_shadow.payload_length = value[5:0];
      CFG_TRAILER_FIRST:  cfg_shadow.trailer_first  = value;
      CFG_TRAILER_SECOND: cfg_shadow.trailer_second = value;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [7:0] h1, input logic [7:0] h2, input logic [7:0] len,
                          input logic [7:0] t1, input logic [7:0] t2);
    write_reg(CFG_HEADER_FIRST, h1);
    write_reg(CFG_HEADER_SECOND, h2);
    write_reg(CFG_PAYLOAD_LENGTH, len);
    write_reg(CFG_TRAILER_FIRST, t1);
    write_reg(CFG_TRAILER_SECOND, t2);
  endtask

  // Wait until every byte is in and every beat is out, then let the drain finish
  task automatic wait_quiet();
    while (rx_pending.size() != 0 || rx_ch.valid || payload_beats_due.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic frame_kind_t pick_frame_kind();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return FRAME_GOOD;
    if (r == 14) return FRAME_BAD_HDR2;
    if (r == 15) return FRAME_BAD_LEN;
    if (r == 16) return FRAME_BAD_TAIL1;
    if (r == 17) return FRAME_BAD_TAIL2;
    if (r == 18) return FRAME_SHORT;
    return FRAME_NOISE;
  endfunction

  task automatic queue_frame(input frame_kind_t kind);
    int unsigned n;
    logic [7:0]  b;
    if (kind == FRAME_NOISE) begin
      // keep noise from opening a frame
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom_range(0, 255));
        if (b == cfg_shadow.header_first) b = ~b;
        rx_pending.push_back(b);
      end
      return;
    end
    rx_pending.push_back(cfg_shadow.header_first);
    b = cfg_shadow.header_second;
    if (kind == FRAME_BAD_HDR2) b ^= 8'($urandom_range(1, 255));
    rx_pending.push_back(b);
    if (kind == FRAME_BAD_HDR2) return;
    b = {2'b00, cfg_shadow.payload_length};
    if (kind == FRAME_BAD_LEN) b ^= 8'($urandom_range(1, 255));
    rx_pending.push_back(b);
    if (kind == FRAME_BAD_LEN) return;
    n = frame_cap();
    if (kind == FRAME_SHORT && n > 0) n = $urandom_range(0, n - 1);
    repeat (n) rx_pending.push_back(8'($urandom_range(0, 255)));
    b = cfg_shadow.trailer_first;
    if (kind == FRAME_BAD_TAIL1) b ^= 8'($urandom_range(1, 255));
    rx_pending.push_back(b);
    if (kind == FRAME_BAD_TAIL1) return;
    b = cfg_shadow.trailer_second;
    if (kind == FRAME_BAD_TAIL2) b ^= 8'($urandom_range(1, 255));
    rx_pending.push_back(b);
  endtask

  task automatic run_phase(input logic [7:0] h1, input logic [7:0] h2, input logic [7:0] len,
                           input logic [7:0] t1, input logic [7:0] t2,
                           input int unsigned frames, input bit src_idle, input bit sink_idle);
    wait_quiet();
    set_regs(h1, h2, len, t1, t2);
    src_idle_on  = src_idle;
    sink_idle_on = sink_idle;
    repeat (frames) queue_frame(pick_frame_kind());
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    rx_ch.valid      = 1'b0;
    rx_ch.rx_byte    = '0;
    payload_ch.ready = 1'b0;
    mismatch_count    = 0;
    long_holds_wanted = 0;
    long_holds_done   = 0;
    src_idle_on       = 1'b1;
    sink_idle_on      = 1'b1;
    frame_phase       = PH_IDLE;
    stored_count      = 0;
    cfg_shadow.header_first   = RstHeaderFirst;
    cfg_shadow.header_second  = RstHeaderSecond;
    cfg_shadow.payload_length = RstPayloadLength;
    cfg_shadow.trailer_first  = RstTrailerFirst;
    cfg_shadow.trailer_second = RstTrailerSecond;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: idle noise, a repeated first header byte that must not
    // restart the frame, and a length byte off by one
    rx_pending = {rx_pending, 8'h00, 8'hFF, 8'h22, 8'h55, 8'h55, 8'h22, 8'h20,
                  8'h55, 8'h22, 8'h1F};
    wait_quiet();
    set_regs(8'hFF, 8'h00, 8'd1, 8'h00, 8'hFF);
    rx_pending = {rx_pending, 8'hFF, 8'h00, 8'h01, 8'hA5, 8'h00, 8'hFF};
    wait_quiet();
    // Zero length: the byte after the length byte is the first trailer, commit emits nothing
    write_reg(CFG_PAYLOAD_LENGTH, 8'd0);
    rx_pending = {rx_pending, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF,
                  8'hFF, 8'h00, 8'h00, 8'h00, 8'hFE};

    // Length above the buffer: full-size payload, length byte still compared;
    // the receiver holds off long enough for the input to back up
    run_phase(8'h55, 8'h22, 8'd40, 8'h01, 8'hAA, 3, 1'b1, 1'b1);
    long_holds_wanted++;
    // Length one, no idling on either side
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd1,
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 15, 1'b0, 1'b0);
    // Largest length field, upper data bits dropped on the length register
    run_phase(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 2, 1'b1, 1'b0);
    wait_quiet();
    for (logic [3:0] i = 4'(CFG_SPARE_LO); i <= 4'(CFG_SPARE_HI); i++)
      write_reg(i[2:0], 8'($urandom_range(0, 255)));
    run_phase(8'hA5, 8'h5A, 8'd0, 8'h3C, 8'hC3, 6, 1'b0, 1'b1);
    repeat (3)
      run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(1, 8)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8, 1'b1, 1'b1);
    run_phase(RstHeaderFirst, RstHeaderSecond, 8'(RstPayloadLength), RstTrailerFirst,
              RstTrailerSecond, 2, 1'b1, 1'b1);

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
design/hltf_pkg.sv
design/hltf_in_if.sv
design/hltf_out_if.sv
design/hltf_parser.sv
design/hltf_drain.sv
design/header_length_tail_frame_parser_core.sv
tb/testbench.sv
